// ----- hdl/dqrb_pkg.sv -----
package dqrb_pkg;

  // queue geometry
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned SLOT_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned ADDR_W = SLOT_W + 1;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned COUNT_W = 16;

  // queue numbers: bit 1 marks a completion queue, bit 0 the receive side
  localparam logic [1:0] Q_SEND_REQ  = 2'd0;
  localparam logic [1:0] Q_RECV_REQ  = 2'd1;
  localparam logic [1:0] Q_SEND_COMP = 2'd2;
  localparam logic [1:0] Q_RECV_COMP = 2'd3;

  // register window offsets
  localparam logic [4:0] OFF_SEND_CMD  = 5'd0;
  localparam logic [4:0] OFF_RECV_BUF  = 5'd8;
  localparam logic [4:0] OFF_SEND_COMP = 5'd16;
  localparam logic [4:0] OFF_RECV_COMP = 5'd18;
  localparam logic [4:0] OFF_COUNTS    = 5'd20;
  localparam logic [4:0] OFF_MAC       = 5'd24;

  typedef enum logic [2:0] {
    OP_BUS_WR    = 3'd0,
    OP_BUS_RD    = 3'd1,
    OP_POP_SEND  = 3'd2,
    OP_POP_RECV  = 3'd3,
    OP_PUSH_SCMP = 3'd4,
    OP_PUSH_RCMP = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_UNMAPPED   = 3'd4
  } status_e;

  // where the result data comes from
  typedef enum logic [2:0] {
    SRC_NONE   = 3'd0,
    SRC_REQ    = 3'd1,
    SRC_CMP    = 3'd2,
    SRC_COUNTS = 3'd3,
    SRC_MAC    = 3'd4
  } src_e;

  typedef struct packed {
    status_e             status;
    src_e                src;
    logic                req_we;
    logic                cmp_we;
    logic                req_re;
    logic                cmp_re;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;
    logic [COUNT_W-1:0]  counts;
  } ctrl_t;

endpackage

// ----- hdl/dqrb_ram.sv -----
module dqrb_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dqrb_ctrl.sv -----
module dqrb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [2:0]                    opcode_i,
  input  logic [4:0]                    offset_i,
  input  logic [dqrb_pkg::DATA_W-1:0]   wdata_i,
  output dqrb_pkg::ctrl_t               ctrl_o
);

  localparam int unsigned SUM_W = dqrb_pkg::CNT_W + 1;

  logic [dqrb_pkg::SLOT_W-1:0] head_q [4];
  logic [dqrb_pkg::CNT_W-1:0]  cnt_q  [4];

  logic [1:0]                  q;
  logic                        do_push;
  logic                        do_pop;
  logic                        misaligned;
  logic                        unmapped;
  logic                        full;
  logic                        empty;
  logic                        push_ok;
  logic                        pop_ok;
  dqrb_pkg::src_e              src_hit;
  logic [SUM_W-1:0]            tail_sum;
  logic [SUM_W-1:0]            head_sum;
  logic [dqrb_pkg::SLOT_W-1:0] tail_slot;
  logic [dqrb_pkg::SLOT_W-1:0] head_nxt;
  logic [dqrb_pkg::CNT_W-1:0]  free_send;
  logic [dqrb_pkg::CNT_W-1:0]  free_recv;

  // decode
  always_comb begin
    q          = dqrb_pkg::Q_SEND_REQ;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    misaligned = 1'b0;
    unmapped   = 1'b0;
    src_hit    = dqrb_pkg::SRC_NONE;
    case (opcode_i)
      dqrb_pkg::OP_BUS_WR: begin
        case (offset_i)
          dqrb_pkg::OFF_SEND_CMD: begin
            q          = dqrb_pkg::Q_SEND_REQ;
            misaligned = (wdata_i[2:0] != 3'd0) || (wdata_i[50:48] != 3'd0);
            do_push    = !misaligned;
          end
          dqrb_pkg::OFF_RECV_BUF: begin
            q          = dqrb_pkg::Q_RECV_REQ;
            misaligned = (wdata_i[2:0] != 3'd0);
            do_push    = !misaligned;
          end
          default: unmapped = 1'b1;
        endcase
      end
      dqrb_pkg::OP_BUS_RD: begin
        case (offset_i)
          dqrb_pkg::OFF_SEND_COMP: begin
            q      = dqrb_pkg::Q_SEND_COMP;
            do_pop = 1'b1;
          end
          dqrb_pkg::OFF_RECV_COMP: begin
            q      = dqrb_pkg::Q_RECV_COMP;
            do_pop = 1'b1;
          end
          dqrb_pkg::OFF_COUNTS: src_hit = dqrb_pkg::SRC_COUNTS;
          dqrb_pkg::OFF_MAC:    src_hit = dqrb_pkg::SRC_MAC;
          default:              unmapped = 1'b1;
        endcase
      end
      dqrb_pkg::OP_POP_SEND: begin
        q      = dqrb_pkg::Q_SEND_REQ;
        do_pop = 1'b1;
      end
      dqrb_pkg::OP_POP_RECV: begin
        q      = dqrb_pkg::Q_RECV_REQ;
        do_pop = 1'b1;
      end
      dqrb_pkg::OP_PUSH_SCMP: begin
        q       = dqrb_pkg::Q_SEND_COMP;
        do_push = 1'b1;
      end
      dqrb_pkg::OP_PUSH_RCMP: begin
        q       = dqrb_pkg::Q_RECV_COMP;
        do_push = 1'b1;
      end
      default: unmapped = 1'b1;
    endcase
  end

  // pointer arithmetic, wrapping at the queue depth
  always_comb begin
    full     = cnt_q[q] >= dqrb_pkg::CNT_W'(dqrb_pkg::QDEPTH);
    empty    = cnt_q[q] == '0;
    push_ok  = do_push && !full;
    pop_ok   = do_pop && !empty;
    tail_sum = SUM_W'(head_q[q]) + SUM_W'(cnt_q[q]);
    if (tail_sum >= SUM_W'(dqrb_pkg::QDEPTH)) begin
      tail_sum = tail_sum - SUM_W'(dqrb_pkg::QDEPTH);
    end
    head_sum = SUM_W'(head_q[q]) + SUM_W'(1);
    if (head_sum >= SUM_W'(dqrb_pkg::QDEPTH)) begin
      head_sum = head_sum - SUM_W'(dqrb_pkg::QDEPTH);
    end
    tail_slot = tail_sum[dqrb_pkg::SLOT_W-1:0];
    head_nxt  = head_sum[dqrb_pkg::SLOT_W-1:0];
    free_send = dqrb_pkg::CNT_W'(dqrb_pkg::QDEPTH) - cnt_q[dqrb_pkg::Q_SEND_REQ];
    free_recv = dqrb_pkg::CNT_W'(dqrb_pkg::QDEPTH) - cnt_q[dqrb_pkg::Q_RECV_REQ];
  end

  always_comb begin
    if (unmapped) begin
      ctrl_o.status = dqrb_pkg::ST_UNMAPPED;
    end else if (misaligned) begin
      ctrl_o.status = dqrb_pkg::ST_MISALIGNED;
    end else if (do_push && full) begin
      ctrl_o.status = dqrb_pkg::ST_FULL;
    end else if (do_pop && empty) begin
      ctrl_o.status = dqrb_pkg::ST_EMPTY;
    end else begin
      ctrl_o.status = dqrb_pkg::ST_OK;
    end
    if (pop_ok) begin
      ctrl_o.src = q[1] ? dqrb_pkg::SRC_CMP : dqrb_pkg::SRC_REQ;
    end else begin
      ctrl_o.src = src_hit;
    end
    ctrl_o.req_we = accept_i && push_ok && !q[1];
    ctrl_o.cmp_we = accept_i && push_ok && q[1];
    ctrl_o.req_re = accept_i && pop_ok && !q[1];
    ctrl_o.cmp_re = accept_i && pop_ok && q[1];
    ctrl_o.waddr  = {q[0], tail_slot};
    ctrl_o.raddr  = {q[0], head_q[q]};
    ctrl_o.counts = {4'(cnt_q[dqrb_pkg::Q_RECV_COMP]), 4'(cnt_q[dqrb_pkg::Q_SEND_COMP]),
                     4'(free_recv), 4'(free_send)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (accept_i) begin
      if (push_ok) begin
        cnt_q[q] <= cnt_q[q] + dqrb_pkg::CNT_W'(1);
      end
      if (pop_ok) begin
        head_q[q] <= head_nxt;
        cnt_q[q]  <= cnt_q[q] - dqrb_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/nic_dma_queue_register_block_top.sv -----
// Register front end of a packet DMA engine with four 8-entry queues: send commands
// and receive buffers pushed by bus writes at offsets 0 and 8, send and receive
// completions pushed by the backend and popped by bus reads at 16 and 18; a read at
// 20 returns the counts word and at 24 the station MAC address. Each input transfer
// (opcode in tuser) yields exactly one output transfer carrying the read or popped
// data and a status code in tuser (0 ok, 1 full, 2 empty, 3 misaligned, 4 unmapped);
// failed accesses return zero data. Queue entries live in two small synchronous
// RAMs, one for requests and one for completions; head pointers and fill counts
// sit in flip-flops and are updated in the cycle the transfer is accepted, so the
// next transfer already sees them. A result passes through the registered RAM read
// of the read stage and then through the output register before it leaves. The block
// accepts one transfer per cycle as long as the output side keeps taking results;
// a stalled output holds one result in the output register and one in the read
// stage before input ready drops. The MAC address register is written through the
// cfg channel, which is always ready, and should only be written while idle.
module nic_dma_queue_register_block_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i,      // mac_address
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // reg_offset[4:0], write_data[68:5], event_data[84:69]
  input  logic [2:0]  s_axis_tuser_i,  // opcode[2:0]
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // data_out[63:0]
  output logic [2:0]  m_axis_tuser_o   // status[2:0]
);

  logic                              accept;
  logic                              s1_move;
  dqrb_pkg::ctrl_t                   ctrl;
  logic [dqrb_pkg::DATA_W-1:0]       req_rdata;
  logic [dqrb_pkg::COMP_W-1:0]       cmp_rdata;
  logic [dqrb_pkg::MAC_W-1:0]        mac_q;

  // read stage
  logic                              s1_valid_q;
  dqrb_pkg::status_e                 s1_status_q;
  dqrb_pkg::src_e                    s1_src_q;
  logic [dqrb_pkg::COUNT_W-1:0]      s1_counts_q;

  // output register
  logic                              out_valid_q;
  logic [dqrb_pkg::DATA_W-1:0]       out_data_q;
  logic [dqrb_pkg::DATA_W-1:0]       out_data_d;
  dqrb_pkg::status_e                 out_status_q;

  // read stage empties into the output register when it is free or draining
  assign s1_move         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_move;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // mac address register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '0;
    end else if (cfg_valid_i) begin
      mac_q <= cfg_data_i;
    end
  end

  // queue pointers and decode
  dqrb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (s_axis_tuser_i),
    .offset_i (s_axis_tdata_i[4:0]),
    .wdata_i  (s_axis_tdata_i[68:5]),
    .ctrl_o   (ctrl)
  );

  // send commands and receive buffers, receive side in the upper half
  dqrb_ram #(
    .WIDTH  (dqrb_pkg::DATA_W),
    .ADDR_W (dqrb_pkg::ADDR_W)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.req_we),
    .waddr_i (ctrl.waddr),
    .wdata_i (s_axis_tdata_i[68:5]),
    .re_i    (ctrl.req_re),
    .raddr_i (ctrl.raddr),
    .rdata_o (req_rdata)
  );

  // send and receive completion words
  dqrb_ram #(
    .WIDTH  (dqrb_pkg::COMP_W),
    .ADDR_W (dqrb_pkg::ADDR_W)
  ) u_cmp_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.cmp_we),
    .waddr_i (ctrl.waddr),
    .wdata_i (s_axis_tdata_i[84:69]),
    .re_i    (ctrl.cmp_re),
    .raddr_i (ctrl.raddr),
    .rdata_o (cmp_rdata)
  );

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= ctrl.status;
      s1_src_q    <= ctrl.src;
      s1_counts_q <= ctrl.counts;
    end
  end

  // pick result data; ram read data holds while the stage is stalled
  always_comb begin
    case (s1_src_q)
      dqrb_pkg::SRC_REQ:    out_data_d = req_rdata;
      dqrb_pkg::SRC_CMP:    out_data_d = {{(dqrb_pkg::DATA_W - dqrb_pkg::COMP_W){1'b0}},
                                          cmp_rdata};
      dqrb_pkg::SRC_COUNTS: out_data_d = {{(dqrb_pkg::DATA_W - dqrb_pkg::COUNT_W){1'b0}},
                                          s1_counts_q};
      dqrb_pkg::SRC_MAC:    out_data_d = {{(dqrb_pkg::DATA_W - dqrb_pkg::MAC_W){1'b0}},
                                          mac_q};
      default:              out_data_d = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q   <= out_data_d;
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  // every accepted transfer lands in the read stage
  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transfer did not reach the read stage");

  // no input taken while both result holders are full and the output is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted with no room for its result");

  // failed accesses carry zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != dqrb_pkg::ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero data on a failed access");

  // ram reads only happen for transfers being accepted
  a_read_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.req_re || ctrl.cmp_re) |-> (accept && (ctrl.status == dqrb_pkg::ST_OK)))
    else $error("queue read without an accepted pop");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // spare opcodes, no mapped function
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int RX_HOLD_CYCLES = 80;   // long output stall, fills the pipeline
  localparam int STALL_LIMIT    = 2000; // cycles without any transfer
  localparam int IDLE_PCT       = 34;

  localparam logic [4:0] MAPPED_OFFSETS [6] = '{
    dqrb_pkg::OFF_SEND_CMD, dqrb_pkg::OFF_RECV_BUF, dqrb_pkg::OFF_SEND_COMP,
    dqrb_pkg::OFF_RECV_COMP, dqrb_pkg::OFF_COUNTS, dqrb_pkg::OFF_MAC
  };

  typedef struct packed {
    logic [63:0]       data;
    dqrb_pkg::status_e status;
  } reply_t;

  // predicts one reply per accepted transfer and checks the replies in order
  class queue_regs_model;
    logic [63:0] slots [4][dqrb_pkg::QDEPTH];
    int unsigned heads [4];
    int unsigned fills [4];
    logic [47:0] mac;
    reply_t      replies [$];
    int          failures;

    function new();
      foreach (heads[i]) begin
        heads[i] = 0;
        fills[i] = 0;
      end
      mac = '0;
      failures = 0;
    endfunction

    function void set_mac(logic [47:0] value);
      mac = value;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function dqrb_pkg::status_e push(logic [1:0] q, logic [63:0] value);
      if (fills[q] >= dqrb_pkg::QDEPTH) return dqrb_pkg::ST_FULL;
      slots[q][(heads[q] + fills[q]) % dqrb_pkg::QDEPTH] = value;
      fills[q]++;
      return dqrb_pkg::ST_OK;
    endfunction

    function dqrb_pkg::status_e pop(logic [1:0] q, output logic [63:0] value);
      value = '0;
      if (fills[q] == 0) return dqrb_pkg::ST_EMPTY;
      value = slots[q][heads[q]];
      heads[q] = (heads[q] + 1) % dqrb_pkg::QDEPTH;
      fills[q]--;
      return dqrb_pkg::ST_OK;
    endfunction

    function logic [63:0] counts_word();
      logic [3:0] send_free, recv_free, send_held, recv_held;
      send_free = 4'(dqrb_pkg::QDEPTH - fills[dqrb_pkg::Q_SEND_REQ]);
      recv_free = 4'(dqrb_pkg::QDEPTH - fills[dqrb_pkg::Q_RECV_REQ]);
      send_held = 4'(fills[dqrb_pkg::Q_SEND_COMP]);
      recv_held = 4'(fills[dqrb_pkg::Q_RECV_COMP]);
      return {48'b0, recv_held, send_held, recv_free, send_free};
    endfunction

    function void note_request(logic [2:0] op, logic [4:0] off, logic [63:0] wdata,
                               logic [15:0] edata);
      logic [63:0] rd;
      dqrb_pkg::status_e st;
      rd = '0;
      st = dqrb_pkg::ST_UNMAPPED;
      case (op)
        dqrb_pkg::OP_BUS_WR: begin
          if (off == dqrb_pkg::OFF_SEND_CMD) begin
            // address and length must both be 8-byte multiples
            if (wdata[2:0] != 3'b0 || wdata[50:48] != 3'b0) st = dqrb_pkg::ST_MISALIGNED;
            else st = push(dqrb_pkg::Q_SEND_REQ, wdata);
          end else if (off == dqrb_pkg::OFF_RECV_BUF) begin
            if (wdata[2:0] != 3'b0) st = dqrb_pkg::ST_MISALIGNED;
            else st = push(dqrb_pkg::Q_RECV_REQ, wdata);
          end
        end
        dqrb_pkg::OP_BUS_RD: begin
          if (off == dqrb_pkg::OFF_SEND_COMP) st = pop(dqrb_pkg::Q_SEND_COMP, rd);
          else if (off == dqrb_pkg::OFF_RECV_COMP) st = pop(dqrb_pkg::Q_RECV_COMP, rd);
          else if (off == dqrb_pkg::OFF_COUNTS) begin
            rd = counts_word();
            st = dqrb_pkg::ST_OK;
          end else if (off == dqrb_pkg::OFF_MAC) begin
            rd = {16'b0, mac};
            st = dqrb_pkg::ST_OK;
          end
        end
        dqrb_pkg::OP_POP_SEND:  st = pop(dqrb_pkg::Q_SEND_REQ, rd);
        dqrb_pkg::OP_POP_RECV:  st = pop(dqrb_pkg::Q_RECV_REQ, rd);
        dqrb_pkg::OP_PUSH_SCMP: st = push(dqrb_pkg::Q_SEND_COMP, {48'b0, edata});
        dqrb_pkg::OP_PUSH_RCMP: st = push(dqrb_pkg::Q_RECV_COMP, {48'b0, edata});
        default:                st = dqrb_pkg::ST_UNMAPPED;
      endcase
      if (st != dqrb_pkg::ST_OK) rd = '0;
      replies.push_back('{data: rd, status: st});
    endfunction

    function void check_reply(logic [63:0] data, logic [2:0] st);
      reply_t exp;
      if (replies.size() == 0) begin
        $display("%0t unexpected result: expected none, actual data %h status %0d",
                 $time, data, st);
        failures++;
        return;
      end
      exp = replies.pop_front();
      if (data !== exp.data) begin
        $display("%0t data_out mismatch: expected %h, actual %h", $time, exp.data, data);
        failures++;
      end
      if (st !== exp.status) begin
        $display("%0t status mismatch: expected %0d, actual %0d", $time, exp.status, st);
        failures++;
      end
    endfunction
  endclass

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // config channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [47:0] cfg_data = '0;

  // input stream
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [87:0] in_data = '0;  // reg_offset, write_data, event_data, zero pad
  logic [2:0]  in_user = '0;  // opcode

  // output stream
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data;      // data_out
  logic [2:0]  out_user;      // status

  // idling knobs for the sender and the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit rx_hold_request = 1'b0;

  int sent = 0;
  int stall_cycles = 0;
  queue_regs_model model;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nic_dma_queue_register_block_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one input transfer; entered and left right after a rising edge.
  // handshakes are sampled at the falling edge, where everything is settled,
  // and the transfer then happens at the next rising edge
  task automatic send_item(logic [2:0] op, logic [4:0] off, logic [63:0] wdata,
                           logic [15:0] edata);
    if (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= {3'b0, edata, wdata, off};
    in_user  <= op;
    do @(negedge clk); while (!in_ready);
    model.note_request(op, off, wdata, edata);
    sent++;
    @(posedge clk);
  endtask

  // mac register write, only while the block is idle
  task automatic write_mac(logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    model.set_mac(value);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  // well-formed push into queue q with random content
  task automatic push_one(logic [1:0] q);
    logic [63:0] w;
    w = rand64();
    case (q)
      dqrb_pkg::Q_SEND_REQ: begin
        w[2:0] = 3'b0;
        w[50:48] = 3'b0;
        send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_SEND_CMD, w, 16'($urandom));
      end
      dqrb_pkg::Q_RECV_REQ: begin
        w[2:0] = 3'b0;
        send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_RECV_BUF, w, 16'($urandom));
      end
      dqrb_pkg::Q_SEND_COMP:
        send_item(dqrb_pkg::OP_PUSH_SCMP, 5'($urandom), w, 16'($urandom));
      default:
        send_item(dqrb_pkg::OP_PUSH_RCMP, 5'($urandom), w, 16'($urandom));
    endcase
  endtask

  // matching pop of queue q: backend pop for requests, bus read for completions
  task automatic pop_one(logic [1:0] q);
    case (q)
      dqrb_pkg::Q_SEND_REQ:
        send_item(dqrb_pkg::OP_POP_SEND, 5'($urandom), rand64(), 16'($urandom));
      dqrb_pkg::Q_RECV_REQ:
        send_item(dqrb_pkg::OP_POP_RECV, 5'($urandom), rand64(), 16'($urandom));
      dqrb_pkg::Q_SEND_COMP:
        send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_SEND_COMP, rand64(), 16'($urandom));
      default:
        send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_RECV_COMP, rand64(), 16'($urandom));
    endcase
  endtask

  // bursts long enough to hit full and empty, with a counts read now and then
  task automatic run_burst();
    logic [1:0] q;
    int n_push, n_pop;
    q = 2'($urandom_range(0, 3));
    n_push = $urandom_range(1, dqrb_pkg::QDEPTH + 2);
    n_pop = $urandom_range(1, dqrb_pkg::QDEPTH + 2);
    repeat (n_push) push_one(q);
    if ($urandom_range(0, 3) == 0)
      send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_COUNTS, rand64(), 16'($urandom));
    repeat (n_pop) pop_one(q);
  endtask

  // anything at all: any opcode, offset and data, misaligned writes included
  task automatic noise_item();
    logic [4:0] off;
    off = 5'($urandom);
    if ($urandom_range(0, 1) == 1) off = MAPPED_OFFSETS[$urandom_range(0, 5)];
    send_item(3'($urandom_range(0, 7)), off, rand64(), 16'($urandom));
  endtask

  task automatic run_random(int target);
    while (sent < target) begin
      if ($urandom_range(0, 99) < 70) run_burst();
      else noise_item();
    end
  endtask

  // receiver: random stalls, or one long hold-off when asked
  always begin
    @(posedge clk);
    if (rx_hold_request) begin
      rx_hold_request = 1'b0;
      out_ready <= 1'b0;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // result checker, sampled where the outputs are settled
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) model.check_reply(out_data, out_user);
  end

  // watchdog on cycles with no transfer anywhere
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    model = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mac(48'hFFFF_FFFF_FFFF);

    // directed: empty state, counts and mac
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_COUNTS, '0, '0);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_MAC, '0, '0);
    send_item(dqrb_pkg::OP_POP_SEND, '0, '0, '0);
    send_item(dqrb_pkg::OP_POP_RECV, '0, '0, '0);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_SEND_COMP, '0, '0);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_RECV_COMP, '0, '0);
    // send command with not-last, top length and top address
    send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_SEND_CMD, 64'hFFF8_FFFF_FFFF_FFF8, '0);
    // misaligned address, then misaligned length
    send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_SEND_CMD, 64'h0000_0000_0000_1001, '0);
    send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_SEND_CMD, 64'h0001_0000_0000_1000, '0);
    send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_RECV_BUF, 64'hFFFF_FFFF_FFFF_FFF8, '0);
    send_item(dqrb_pkg::OP_BUS_WR, dqrb_pkg::OFF_RECV_BUF, 64'h0000_0000_0000_0004, '0);
    send_item(dqrb_pkg::OP_PUSH_SCMP, 5'h1F, '1, 16'hFFFF);
    send_item(dqrb_pkg::OP_PUSH_RCMP, 5'h1F, '1, 16'h0000);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_COUNTS, '1, '1);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_SEND_COMP, '0, '0);
    send_item(dqrb_pkg::OP_BUS_RD, dqrb_pkg::OFF_RECV_COMP, '0, '0);
    send_item(dqrb_pkg::OP_POP_SEND, '0, '0, '0);
    send_item(dqrb_pkg::OP_POP_RECV, '0, '0, '0);
    // unmapped offsets and spare opcodes
    send_item(dqrb_pkg::OP_BUS_WR, 5'h1F, 64'h0000_0000_0000_0008, '0);
    send_item(dqrb_pkg::OP_BUS_RD, 5'h00, '0, '0);
    send_item(dqrb_pkg::OP_BUS_RD, 5'h1F, '0, '0);
    send_item(OP_SPARE6, dqrb_pkg::OFF_SEND_CMD, '0, '0);
    send_item(OP_SPARE7, dqrb_pkg::OFF_MAC, '1, '1);

    // random, both sides idling
    drain();
    write_mac('0);
    run_random(420);

    // random with no idling at all
    drain();
    write_mac(48'($urandom) | (48'($urandom) << 32));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(750);

    // long receiver hold-off while the sender keeps offering
    drain();
    write_mac(48'hFFFF_FFFF_FFFF);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_request = 1'b1;
    run_random(1100);

    // sender pause mid-stream until all results are back
    drain();
    run_random(1300);
    rx_hold_request = 1'b1;
    run_random(1520);

    drain();
    repeat (20) @(posedge clk);
    if (model.failures == 0 && model.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/dqrb_pkg.sv
hdl/dqrb_ram.sv
hdl/dqrb_ctrl.sv
hdl/nic_dma_queue_register_block_top.sv
test/tb_top.sv
